// File: hdl/lkcm_pkg.sv
// lkcm_pkg: shared constants, types and keyword table of the line keyword matcher
// used by the other hdl modules but lkcm_out_reg, and by tb_top; depends on nothing else
package lkcm_pkg;

  // default line length, one byte less than this is held
  localparam int MaxLenDefault = 32;

  // special bytes
  localparam logic [7:0] ByteCr   = 8'd13;
  localparam logic [7:0] ByteLf   = 8'd10;
  localparam logic [7:0] ByteZero = 8'd0;

  // keyword table
  localparam int KwNum = 9;
  localparam int KwMax = 11;

  // command codes
  localparam logic [3:0] CodeUnknown = 4'd0;

  // keywords, right aligned in the packed word, unused upper bytes zero
  localparam logic [KwMax*8-1:0] KW_TEXT [KwNum] = '{
    (KwMax*8)'("UP"),
    (KwMax*8)'("DOWN"),
    (KwMax*8)'("LEFT"),
    (KwMax*8)'("RIGHT"),
    (KwMax*8)'("OK"),
    (KwMax*8)'("BACK"),
    (KwMax*8)'("FUNCTION"),
    (KwMax*8)'("BACK_LONG"),
    (KwMax*8)'("GET_DISPLAY")
  };

  localparam logic [3:0] KW_LEN [KwNum] = '{
    4'd2, 4'd4, 4'd4, 4'd5, 4'd2, 4'd4, 4'd8, 4'd9, 4'd11
  };

  // registered input item with its decode
  typedef struct packed {
    logic       valid;
    logic       is_cr;
    logic       is_lf;
    logic [7:0] data;
  } step_t;

  // character pos of keyword kw, only meaningful for pos below its length
  function automatic logic [7:0] kw_char(input logic [3:0] kw, input logic [3:0] pos);
    logic [KwMax*8-1:0] text;
    logic [3:0]         sh;
    text = KW_TEXT[kw];
    sh   = KW_LEN[kw] - pos - 4'd1;
    return text[{sh, 3'b000} +: 8];
  endfunction

endpackage

// File: hdl/lkcm_in_reg.sv
// lkcm_in_reg: input register of the line keyword matcher, decodes line control bytes
// depends on lkcm_pkg
module lkcm_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                advance_i,
  output lkcm_pkg::step_t     step_o
);

  lkcm_pkg::step_t step_q, step_d;
  logic            accept;

  // stall only while the held item cannot move on
  assign in_stall_o = step_q.valid && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // next contents of the input register
  always_comb begin
    step_d = step_q;
    if (accept) begin
      step_d.valid = 1'b1;
      step_d.is_cr = (rx_byte_i == lkcm_pkg::ByteCr);
      step_d.is_lf = (rx_byte_i == lkcm_pkg::ByteLf);
      step_d.data  = rx_byte_i;
    end else if (advance_i) begin
      step_d.valid = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign step_o = step_q;

endmodule

// File: hdl/lkcm_matcher.sv
// lkcm_matcher: line state and per keyword match flags, gives the code of the line
// depends on lkcm_pkg
module lkcm_matcher #(
  parameter int MAX_LEN = lkcm_pkg::MaxLenDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkcm_pkg::step_t step_i,
  input  logic            advance_i,
  output logic [3:0]      code_o
);

  localparam int StoreDepth = MAX_LEN - 1;
  localparam int CntW       = $clog2(MAX_LEN);

  logic [CntW-1:0]           fill_q, fill_d;
  logic [CntW-1:0]           text_len_q, text_len_d;
  logic                      zero_seen_q, zero_seen_d;
  logic [lkcm_pkg::KwNum-1:0] match_q, match_d;
  logic                      full;

  assign full = (fill_q == CntW'(StoreDepth));

  // state update for one byte
  always_comb begin
    fill_d      = fill_q;
    text_len_d  = text_len_q;
    zero_seen_d = zero_seen_q;
    match_d     = match_q;
    if (advance_i && !step_i.is_cr) begin
      if (step_i.is_lf || full) begin
        // line end or overflow: start an empty line
        fill_d      = '0;
        text_len_d  = '0;
        zero_seen_d = 1'b0;
        match_d     = '1;
      end else begin
        fill_d = fill_q + CntW'(1);
        if (!zero_seen_q) begin
          if (step_i.data == lkcm_pkg::ByteZero) begin
            // text ends at the first zero byte
            zero_seen_d = 1'b1;
          end else begin
            text_len_d = text_len_q + CntW'(1);
            for (int k = 0; k < lkcm_pkg::KwNum; k++) begin
              match_d[k] = match_q[k] && (fill_q < CntW'(lkcm_pkg::KW_LEN[k])) &&
                           (lkcm_pkg::kw_char(4'(k), fill_q[3:0]) == step_i.data);
            end
          end
        end
      end
    end
  end

  // code of the current line, first keyword wins
  always_comb begin
    code_o = lkcm_pkg::CodeUnknown;
    for (int k = lkcm_pkg::KwNum - 1; k >= 0; k--) begin
      if (match_q[k] && (text_len_q == CntW'(lkcm_pkg::KW_LEN[k]))) begin
        code_o = 4'(k + 1);
      end
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      text_len_q  <= '0;
      zero_seen_q <= 1'b0;
      match_q     <= '1;
    end else begin
      fill_q      <= fill_d;
      text_len_q  <= text_len_d;
      zero_seen_q <= zero_seen_d;
      match_q     <= match_d;
    end
  end

endmodule

// File: hdl/lkcm_out_reg.sv
// lkcm_out_reg: result register of the line keyword matcher, holds a code until taken
// depends on nothing else
module lkcm_out_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [3:0] code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] command_code_o
);

  logic       valid_q, valid_d;
  logic [3:0] code_q;

  // load wins, otherwise drop the item once taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign command_code_o = code_q;

endmodule

// File: hdl/line_keyword_command_matcher_unit.sv
// line_keyword_command_matcher_unit: top level of the line keyword matcher
// depends on lkcm_pkg, lkcm_in_reg, lkcm_matcher and lkcm_out_reg

// Takes one received byte per cycle while not stalled. Carriage returns are
// ignored, other bytes build a line of up to MAX_LEN-1 bytes, an overflowing
// byte clears the line, and a line feed gives one command code (0 unknown or
// empty, 1 to 9 for the keywords UP, DOWN, LEFT, RIGHT, OK, BACK, FUNCTION,
// BACK_LONG, GET_DISPLAY). The line text is not stored: each byte updates one
// match flag per keyword in the same cycle, so a byte is taken every cycle
// while not stalled, and a line feed is held in the input register and its
// code in the result register. A line feed waits in the input register only
// while the previous code is still held and stalled in the result register.
module line_keyword_command_matcher_unit #(
  parameter int MAX_LEN = lkcm_pkg::MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] command_code_o
);

  lkcm_pkg::step_t step;
  logic            advance;
  logic            load;
  logic [3:0]      code;

  // the held item moves on unless it is a line feed and the result slot is busy
  assign advance = step.valid && (!step.is_lf || !out_valid_o || !out_stall_i);
  assign load    = advance && step.is_lf;

  lkcm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .step_o     (step)
  );

  lkcm_matcher #(
    .MAX_LEN (MAX_LEN)
  ) u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .advance_i (advance),
    .code_o    (code)
  );

  lkcm_out_reg u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .code_i         (code),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_code_o (command_code_o)
  );

  // input stalls only while an item is held
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> step.valid)
    else $error("input stalled with no item held");

  // a new code comes only from a line feed that moved on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(advance && step.is_lf))
    else $error("result item without a line feed");

  // a held line feed waits while the previous code is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.valid && step.is_lf && out_valid_o && out_stall_i) |-> !advance)
    else $error("line feed overwrote a pending code");

  // codes stay within the keyword range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (command_code_o <= 4'(lkcm_pkg::KwNum)))
    else $error("command code out of range");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for line_keyword_command_matcher_unit
// sends received bytes, predicts each command code and checks the codes in order
// depends on lkcm_pkg and the top level under hdl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreDepth  = lkcm_pkg::MaxLenDefault - 1;
  localparam int ClkHalf     = 4;
  localparam int CycleLimit  = 500000;
  localparam int DrainLimit  = 4000;
  localparam int TotalItems  = 1450;

  typedef enum logic [3:0] {
    CMD_UNKNOWN   = 4'd0,
    CMD_UP        = 4'd1,
    CMD_DOWN      = 4'd2,
    CMD_LEFT      = 4'd3,
    CMD_RIGHT     = 4'd4,
    CMD_OK        = 4'd5,
    CMD_BACK      = 4'd6,
    CMD_FUNCTION  = 4'd7,
    CMD_HOLD_BACK = 4'd8,
    CMD_READ_DISP = 4'd9
  } cmd_code_e;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] rx_byte_i  = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] command_code_o;

  // predicted line state and pending codes
  logic [7:0]  line_mem [StoreDepth];
  int unsigned line_fill = 0;
  logic [3:0]  code_q [$];
  logic [7:0]  frame_q [$];

  int unsigned error_cnt = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          src_idle  = 1'b0;
  bit          sink_idle = 1'b0;

  line_keyword_command_matcher_unit #(
    .MAX_LEN(lkcm_pkg::MaxLenDefault)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .command_code_o(command_code_o)
  );

  // clock
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("line_keyword_command_matcher_unit: mismatch");
      $finish;
    end
  end

  // keyword text of a command code
  function automatic string keyword_of(input cmd_code_e code);
    case (code)
      CMD_UP:        return "UP";
      CMD_DOWN:      return "DOWN";
      CMD_LEFT:      return "LEFT";
      CMD_RIGHT:     return "RIGHT";
      CMD_OK:        return "OK";
      CMD_BACK:      return "BACK";
      CMD_FUNCTION:  return "FUNCTION";
      CMD_HOLD_BACK: return "BACK_LONG";
      CMD_READ_DISP: return "GET_DISPLAY";
      default:       return "";
    endcase
  endfunction

  // exact match of the held text, cut at the first zero byte
  function automatic logic [3:0] decode_line();
    int unsigned text_len;
    string       kw;
    logic [3:0]  hit;
    bit          same;
    text_len = 0;
    while (text_len < line_fill && line_mem[text_len] != lkcm_pkg::ByteZero) text_len++;
    hit = CMD_UNKNOWN;
    for (int k = CMD_UP; k <= CMD_READ_DISP; k++) begin
      kw = keyword_of(cmd_code_e'(k));
      if (hit == CMD_UNKNOWN && kw.len() == text_len) begin
        same = 1'b1;
        for (int i = 0; i < text_len; i++) begin
          if (line_mem[i] != kw[i]) same = 1'b0;
        end
        if (same) hit = k[3:0];
      end
    end
    return hit;
  endfunction

  // update the predicted line with one accepted byte
  function automatic void absorb_byte(input logic [7:0] b);
    if (b == lkcm_pkg::ByteLf) begin
      code_q.push_back(decode_line());
      line_fill = 0;
    end else if (b != lkcm_pkg::ByteCr) begin
      if (line_fill < StoreDepth) begin
        line_mem[line_fill] = b;
        line_fill++;
      end else begin
        // full store: byte dropped and line cleared
        line_fill = 0;
        foreach (line_mem[i]) line_mem[i] = lkcm_pkg::ByteZero;
      end
    end
  endfunction

  function automatic logic [7:0] rand_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == lkcm_pkg::ByteLf);
    return b;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void push_repeat(input logic [7:0] b, input int unsigned n);
    repeat (n) frame_q.push_back(b);
  endfunction

  // send one item, wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    absorb_byte(b);
    sent_cnt++;
  endtask

  task automatic send_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic send_line(input string s);
    push_text(s);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
  endtask

  // hold the input off until every predicted code has come out
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (code_q.size() != 0 && waited < DrainLimit);
    if (code_q.size() != 0) begin
      $error("command_code expected %0d, actual none", code_q[0]);
      error_cnt++;
      code_q.delete();
    end
  endtask

  // result side: stall each item for a drawn number of cycles when idling is on
  initial begin
    int unsigned hold;
    wait (rst_ni == 1'b1);
    forever begin
      hold = sink_idle ? $urandom_range(0, 16) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (hold - 1) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each taken code with the oldest prediction
  always @(posedge clk_i) begin : check_codes
    logic [3:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (code_q.size() == 0) begin
        $error("command_code expected none, actual %0d", command_code_o);
        error_cnt++;
      end else begin
        want = code_q.pop_front();
        if (command_code_o !== want) begin
          $error("command_code expected %0d, actual %0d", want, command_code_o);
          error_cnt++;
        end
      end
    end
  end

  // every keyword and the empty line, back to back
  task automatic test_every_keyword();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    for (int k = CMD_UP; k <= CMD_READ_DISP; k++) send_line(keyword_of(cmd_code_e'(k)));
    send_line("");
    send_line("");
    wait_results_drained();
  endtask

  // near misses, carriage returns, zero bytes and extreme byte values
  task automatic test_line_edges();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_line("up");
    send_line("BAC");
    send_line("BACK_LONGX");
    // carriage returns inside a line
    push_text("LE");
    frame_q.push_back(lkcm_pkg::ByteCr);
    push_text("FT");
    frame_q.push_back(lkcm_pkg::ByteCr);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    frame_q.push_back(lkcm_pkg::ByteCr);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    // zero byte ends the text
    push_text("OK");
    frame_q.push_back(lkcm_pkg::ByteZero);
    push_text("Z");
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    frame_q.push_back(lkcm_pkg::ByteZero);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    // top bit set
    frame_q.push_back(8'hFF);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    frame_q.push_back(8'hD5);
    push_text("P");
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    wait_results_drained();
  endtask

  // full line, overflow clears and matching after a clear
  task automatic test_store_overflow();
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    push_repeat("A", StoreDepth);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    push_repeat("A", StoreDepth);
    push_text("BRIGHT");
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    push_text("GET_DISPLAY");
    frame_q.push_back(lkcm_pkg::ByteZero);
    push_repeat(8'hFF, StoreDepth - 12);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    push_text("FUNCTION");
    push_repeat("x", StoreDepth - 8 + 1);
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    push_repeat(8'h00, StoreDepth + 1);
    push_repeat(8'h7F, StoreDepth + 1);
    push_text("OK");
    frame_q.push_back(lkcm_pkg::ByteLf);
    send_frame();
    wait_results_drained();
  endtask

  // one random line, mostly keyword based
  task automatic random_line();
    int unsigned kind;
    int unsigned pos;
    bit          end_line;
    string       kw;
    kind     = $urandom_range(0, 99);
    kw       = keyword_of(cmd_code_e'($urandom_range(CMD_UP, CMD_READ_DISP)));
    end_line = 1'b1;
    if (kind < 45) begin
      push_text(kw);
    end else if (kind < 60) begin
      // keyword with one damaged spot
      push_text(kw);
      pos = $urandom_range(0, frame_q.size() - 1);
      case ($urandom_range(0, 4))
        0:       frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
        1:       frame_q[pos] = frame_q[pos] ^ 8'h20;
        2:       void'(frame_q.pop_back());
        3:       frame_q.push_back(rand_plain_byte());
        default: frame_q.push_front(rand_plain_byte());
      endcase
    end else if (kind < 70) begin
      push_text(kw);
      frame_q.push_back(lkcm_pkg::ByteZero);
      repeat ($urandom_range(0, 6)) frame_q.push_back(rand_plain_byte());
    end else if (kind < 80) begin
      repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      // run past the end of the store
      repeat ($urandom_range(StoreDepth - 3, StoreDepth + 9)) frame_q.push_back(rand_plain_byte());
      if ($urandom_range(0, 1)) push_text(kw);
    end else begin
      // noise with no line end, or a bare line feed
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 6)) frame_q.push_back(rand_plain_byte());
        end_line = 1'b0;
      end
    end
    if (end_line) frame_q.push_back(lkcm_pkg::ByteLf);
    while (frame_q.size() != 0) begin
      if ($urandom_range(0, 15) == 0) send_byte(lkcm_pkg::ByteCr);
      send_byte(frame_q.pop_front());
    end
  endtask

  // random lines with changing idle patterns and one full pause midway
  task automatic test_random_traffic();
    int unsigned first;
    bit          paused;
    first     = sent_cnt;
    paused    = 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    while (sent_cnt < TotalItems) begin
      if ($urandom_range(0, 9) == 0) begin
        src_idle  = ($urandom_range(0, 99) < 60);
        sink_idle = ($urandom_range(0, 99) < 60);
      end
      if (!paused && sent_cnt >= first + (TotalItems - first) / 2) begin
        wait_results_drained();
        paused = 1'b1;
      end
      random_line();
    end
  endtask

  // sequence
  initial begin
    foreach (line_mem[i]) line_mem[i] = lkcm_pkg::ByteZero;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_every_keyword();
    test_line_edges();
    test_store_overflow();
    test_random_traffic();
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("line_keyword_command_matcher_unit: match");
    end else begin
      $display("line_keyword_command_matcher_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lkcm_pkg.sv
hdl/lkcm_in_reg.sv
hdl/lkcm_matcher.sv
hdl/lkcm_out_reg.sv
hdl/line_keyword_command_matcher_unit.sv
verif/tb_top.sv
